@@ rtl/core/sitd_pkg.sv @@
// shared types and constants for the signed integer to decimal text converter
`default_nettype none

package sitd_pkg;

  // width of the value port as seen by the outside
  localparam int VALUE_W = 32;

  // width of the character and count fields
  localparam int CHAR_W     = 8;
  localparam int CHAR_CNT_W = 4;

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // largest value a decimal digit may hold
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // per-cycle command handed to every digit cell
  typedef struct packed {
    logic clear;   // start of a new conversion
    logic dabble;  // add-3 correction and shift in one magnitude bit
    logic move;    // pass digit to the next higher cell
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/sitd_digit_cell.sv @@
// one bcd digit cell of the double-dabble chain
`default_nettype none

module sitd_digit_cell
  import sitd_pkg::*;
(
  input  wire        clk,
  input  wire cell_ctrl_t ctrl,
  input  wire        carry_in,
  input  wire  [3:0] digit_in,
  output logic       carry_out,
  output logic [3:0] digit
);

  logic [3:0] adj;

  // correct digits of five and up before doubling
  always_comb begin
    adj       = (digit > 4'd4) ? (digit + 4'd3) : digit;
    carry_out = adj[3];
  end

  always_ff @(posedge clk) begin
    priority if (ctrl.clear) begin
      digit <= 4'd0;
    end else if (ctrl.dabble) begin
      digit <= {adj[2:0], carry_in};
    end else if (ctrl.move) begin
      digit <= digit_in;
    end else begin
      digit <= digit;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/signed_int_to_decimal_ascii.sv @@
// top level: signed binary integer in, decimal ascii characters out
//
//  channel   direction  handshake               payload
//  value     in         value_valid/value_stall value[31:0] signed
//  char      out        char_valid/char_stall   ascii_char[7:0], last, char_count[3:0]
//
// a request runs through the states conv (the bit-serial double-dabble pass through
// the digit chain), align (leading zero digits dropped), sign (negative values only)
// and emit (one character per digit, most significant first).
// reset is synchronous, clears the sequencer and the output valid, and stalls input.
// a stalled character holds the sequencer in the sign and emit states; a new request is taken
// as soon as the last character has been loaded into the output register.
`default_nettype none

module signed_int_to_decimal_ascii
  import sitd_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         value_valid,
  output logic                        value_stall,
  input  wire signed [VALUE_W-1:0]    value,
  output logic                        char_valid,
  input  wire                         char_stall,
  output logic       [CHAR_W-1:0]     ascii_char,
  output logic                        last,
  output logic       [CHAR_CNT_W-1:0] char_count
);

  // decimal digits needed for a magnitude up to 2^(VALUE_BITS-1)
  localparam int NDIG  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int CW    = $clog2(VALUE_BITS + 1);
  localparam int DW    = $clog2(NDIG + 1);
  localparam int SUM_W = DW + 1;

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_ALIGN = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]            state;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] mag_sr;
  logic                  neg;
  logic [CW-1:0]         bit_cnt;
  logic [DW-1:0]         digits_left;
  logic [CHAR_CNT_W-1:0] char_total;
  logic [SUM_W-1:0]      total_sum;

  logic       accept;
  logic       out_load;
  logic       skip;
  logic [3:0] top_digit;
  cell_ctrl_t cell_ctrl;

  logic       carry [NDIG+1];
  logic [3:0] digit [NDIG];

  // take the low VALUE_BITS bits of the port, zero-extended when wider
  if (VALUE_BITS <= VALUE_W) begin : g_narrow
    assign raw = value[VALUE_BITS-1:0];
  end else begin : g_wide
    assign raw = {{(VALUE_BITS - VALUE_W){1'b0}}, value};
  end

  // unsigned magnitude; the most negative value maps to 2^(VALUE_BITS-1)
  assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  // no request is taken while reset is held
  assign value_stall = rst || (state != ST_IDLE);
  assign accept      = value_valid && !value_stall;
  assign out_load    = !char_valid || !char_stall;
  assign top_digit   = digit[NDIG-1];

  // leading zero suppression: drop zero digits but always keep one
  assign skip = (top_digit == 4'd0) && (digits_left != DW'(1));

  assign total_sum = SUM_W'(digits_left) + SUM_W'(neg);

  always_comb begin
    cell_ctrl.clear  = accept;
    cell_ctrl.dabble = (state == ST_CONV);
    cell_ctrl.move   = ((state == ST_ALIGN) && skip) ||
                       ((state == ST_EMIT) && out_load);
  end

  // ---------------------------------------------------------------------------
  // digit chain: cell 0 is the ones digit, bits enter there from the
  // shift register msb; during output digits walk toward the top cell
  // ---------------------------------------------------------------------------
  assign carry[0] = mag_sr[VALUE_BITS-1];

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    logic [3:0] lower_digit;

    if (i == 0) begin : g_first
      assign lower_digit = 4'd0;
    end else begin : g_rest
      assign lower_digit = digit[i-1];
    end

    sitd_digit_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .carry_in  (carry[i]),
      .digit_in  (lower_digit),
      .carry_out (carry[i+1]),
      .digit     (digit[i])
    );
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (bit_cnt == CW'(1)) begin
            state <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          if (!skip) begin
            state <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (out_load) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load && (digits_left == DW'(1))) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers of the sequencer
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_sr  <= mag;
      neg     <= raw[VALUE_BITS-1];
      bit_cnt <= CW'(VALUE_BITS);
    end else if (state == ST_CONV) begin
      mag_sr  <= {mag_sr[VALUE_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt - 1'b1;
    end

    if (state == ST_CONV) begin
      digits_left <= DW'(NDIG);
    end else if ((state == ST_ALIGN) && skip) begin
      digits_left <= digits_left - 1'b1;
    end else if ((state == ST_EMIT) && out_load) begin
      digits_left <= digits_left - 1'b1;
    end

    // count is kept modulo 16 for very wide values
    if ((state == ST_ALIGN) && !skip) begin
      char_total <= CHAR_CNT_W'(total_sum);
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (out_load && ((state == ST_SIGN) || (state == ST_EMIT))) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && (state == ST_SIGN)) begin
      ascii_char <= CHAR_MINUS;
      last       <= 1'b0;
      char_count <= '0;
    end else if (out_load && (state == ST_EMIT)) begin
      ascii_char <= CHAR_ZERO + {4'd0, top_digit};
      last       <= (digits_left == DW'(1));
      char_count <= (digits_left == DW'(1)) ? char_total : '0;
    end
  end

`ifndef ASSERT_OFF
  // a taken request always starts the bit-serial pass
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CONV))
    else $error("accepted request did not start conversion");

  // the top cell holds a proper decimal digit once the pass is done
  a_top_bcd: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_ALIGN) || (state == ST_EMIT)) |-> (top_digit <= DIGIT_MAX))
    else $error("digit chain holds a non-decimal digit");

  // the digit counter never runs out while characters remain
  a_digits_left: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SIGN) || (state == ST_EMIT)) |-> (digits_left != '0))
    else $error("digit counter empty during output");

  // only a minus sign or a digit reaches the output
  a_char_code: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> ((ascii_char == CHAR_MINUS) ||
                    ((ascii_char >= CHAR_ZERO) &&
                     (ascii_char <= (CHAR_ZERO + 8'd9)))))
    else $error("illegal character code on output");
`endif

endmodule

`default_nettype wire

@@ tb/sv/signed_int_to_decimal_ascii_tb.sv @@
// self-checking testbench for the signed integer to decimal ascii converter
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;
  import sitd_pkg::*;

  // run sizing
  localparam int RANDOM_VALUES = 186;
  localparam int IDLE_LIMIT    = 4000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES  = 60;    // a little over one conversion

  // one expected character of the decimal text
  typedef struct packed {
    logic [CHAR_W-1:0]     ch;
    logic                  last;
    logic [CHAR_CNT_W-1:0] count;
  } text_char_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  value_valid = 1'b0;
  logic                  value_stall;
  logic [VALUE_W-1:0]    value = '0;
  logic                  char_valid;
  logic                  char_stall = 1'b0;
  logic [CHAR_W-1:0]     ascii_char;
  logic                  last;
  logic [CHAR_CNT_W-1:0] char_count;

  // characters still owed by the converter, oldest first
  text_char_t text_q[$];
  text_char_t want;

  int errors      = 0;
  int values_sent = 0;
  int negatives   = 0;
  int chars_seen  = 0;
  int texts_done  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  // receiver stall pattern state
  int stall_mode = 0;
  int stall_left = 0;

  always #6 clk = ~clk;

  signed_int_to_decimal_ascii u_dut (
    .clk        (clk),
    .rst        (rst),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .value      (value),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .ascii_char (ascii_char),
    .last       (last),
    .char_count (char_count)
  );

  // work out the decimal text of one request and queue its characters
  task automatic queue_decimal_text(input logic [VALUE_W-1:0] v);
    logic             negative;
    logic [VALUE_W:0] mag;
    logic [3:0]       digits [0:15];
    int               ndig;
    int               total;
    int               i;
    text_char_t       c;
    negative = v[VALUE_W-1];
    // one bit wider so the most negative value keeps its full magnitude
    mag = negative ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    ndig = 0;
    // zero still produces one digit
    do begin
      digits[ndig] = 4'(mag % 10);
      mag = mag / 10;
      ndig++;
    end while (mag != 0);
    total = ndig + (negative ? 1 : 0);
    if (negative) begin
      negatives++;
      c.ch    = CHAR_MINUS;
      c.last  = 1'b0;
      c.count = '0;
      text_q.push_back(c);
    end
    // most significant digit goes out first
    for (i = ndig - 1; i >= 0; i--) begin
      c.ch    = CHAR_ZERO + digits[i];
      c.last  = (i == 0);
      c.count = (i == 0) ? total[CHAR_CNT_W-1:0] : '0;
      text_q.push_back(c);
    end
  endtask

  // send one request; the sender runs in bursts with random gaps in between
  // valid is only lowered at the start of a gap, so back-to-back requests
  // never see valid dropped and raised in the same step
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 7))
        0, 1, 2: gap = 0;
        7:       gap = $urandom_range(20, 60);
        default: gap = $urandom_range(1, 10);
      endcase
      if (gap > 0) begin
        value_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    value_valid <= 1'b1;
    value       <= v;
    // wait for the edge that takes the request
    do @(posedge clk); while (value_stall);
    values_sent++;
    queue_decimal_text(v);
  endtask

  // random value shaped toward digit-count boundaries and the range ends
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    int                 k;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2:    v = $urandom_range(0, 999);
      3: begin
        // around a power of ten, where the digit count changes
        p = 1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
      end
      4:       v = 32'h7FFF_FFF8 + $urandom_range(0, 7);
      default: v = 32'h8000_0000 + $urandom_range(0, 7);
    endcase
    if ($urandom_range(0, 1) == 1 && v[VALUE_W-1] == 1'b0)
      v = -v;
    return v;
  endfunction

  task automatic test_zero_and_single_digits();
    send_value(32'd0);
    send_value(32'd1);
    send_value(-32'sd1);
    send_value(32'd5);
    send_value(-32'sd7);
    send_value(32'd9);
  endtask

  task automatic test_range_extremes();
    send_value(32'h7FFF_FFFF);
    // most negative value: minus sign and all ten digits
    send_value(32'h8000_0000);
    send_value(32'h8000_0001);
    send_value(32'hFFFF_FFFE);
  endtask

  task automatic test_digit_lengths();
    send_value(32'd10);
    send_value(-32'sd10);
    send_value(32'd99);
    send_value(-32'sd100);
    send_value(32'd1000);
    send_value(32'd99999);
    send_value(32'd100000);
    send_value(-32'sd999999);
    send_value(32'd1000000);
    send_value(32'd10000000);
    send_value(-32'sd99999999);
    send_value(32'd999999999);
    send_value(32'd1000000000);
    send_value(-32'sd1000000000);
  endtask

  task automatic test_random_values(input int n);
    int i;
    for (i = 0; i < n; i++)
      send_value(pick_value());
  endtask

  // receiver stall: a mode is held for a random stretch, from no stall at all
  // through light and heavy random stalls to a fixed on/off pattern
  always @(posedge clk) begin
    if (rst) begin
      char_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(16, 96);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       char_stall <= 1'b0;
        1:       char_stall <= ($urandom_range(0, 99) < 30);
        2:       char_stall <= ($urandom_range(0, 99) < 75);
        default: char_stall <= stall_left[2];
      endcase
    end
  end

  // compare every accepted character against the oldest expectation
  always @(posedge clk) begin
    if (!rst && char_valid && !char_stall) begin
      chars_seen++;
      if (text_q.size() == 0) begin
        errors++;
        $display("%0t: character with no request pending: expected none, actual char %0d",
                 $time, ascii_char);
      end else begin
        want = text_q.pop_front();
        if (ascii_char !== want.ch) begin
          errors++;
          $display("%0t: ascii_char mismatch: expected %0d, actual %0d",
                   $time, want.ch, ascii_char);
        end
        if (last !== want.last) begin
          errors++;
          $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, last);
        end
        if (char_count !== want.count) begin
          errors++;
          $display("%0t: char_count mismatch: expected %0d, actual %0d",
                   $time, want.count, char_count);
        end
        if (want.last)
          texts_done++;
      end
    end
  end

  // watchdog: too long without any handshake means the block is stuck
  always @(posedge clk) begin
    if ((value_valid && !value_stall) || (char_valid && !char_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d characters outstanding",
               $time, IDLE_LIMIT, text_q.size());
      $display("** signed_int_to_decimal_ascii: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_zero_and_single_digits();
    test_range_extremes();
    test_digit_lengths();
    test_random_values(RANDOM_VALUES);

    // stop sending, let every owed character come out, then watch for strays
    value_valid <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d values (%0d negative) into %0d characters, %0d texts complete",
             values_sent, negatives, chars_seen, texts_done);
    $display("covered zero, single digits, every text length and both range ends");
    if (errors == 0)
      $display("** signed_int_to_decimal_ascii: PASSED **");
    else
      $display("** signed_int_to_decimal_ascii: FAILED **");
    $finish;
  end

endmodule
